// ----- rtl/bdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// bdlp_pkg
// Shared types and constants of the button debounce / long-press unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = TimerW;

  localparam logic [TimerW-1:0] TimerMax = 16'hFFFF;

  typedef enum logic [2:0] {
    EV_NONE    = 3'd0,
    EV_PRESS   = 3'd1,
    EV_SHORT   = 3'd2,
    EV_LONG    = 3'd3,
    EV_RELEASE = 3'd4
  } event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_LEVEL = 2'd0,
    CFG_DEBOUNCE     = 2'd1,
    CFG_LONG_PRESS   = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  localparam logic              RstActiveLevel = 1'b0;
  localparam logic [TimerW-1:0] RstDebounce    = 16'd20;
  localparam logic [TimerW-1:0] RstLongPress   = 16'd1000;

  typedef struct packed {
    logic              press_level;
    logic [TimerW-1:0] debounce_time;
    logic [TimerW-1:0] long_press_time;
  } cfg_t;

  typedef struct packed {
    logic              prev_pin_pressed;
    logic              stable_pressed;
    logic              long_done;
    event_e            pending;
    logic [TimerW-1:0] steady_timer;
    logic [TimerW-1:0] held_timer;
  } state_t;

  localparam state_t StateRst = '{
    prev_pin_pressed: 1'b0,
    stable_pressed:   1'b0,
    long_done:        1'b0,
    pending:          EV_NONE,
    steady_timer:     '0,
    held_timer:       '0
  };

  function automatic logic [TimerW-1:0] sat_add(input logic [TimerW-1:0] a,
                                                input logic [TimerW-1:0] b);
    logic [TimerW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimerW] ? TimerMax : s[TimerW-1:0];
  endfunction

endpackage

// ----- rtl/bdlp_if.sv -----
// ----------------------------------------------------------------------------
// bdlp_in_if / bdlp_out_if
// Valid/ready channels of the button unit: scan/fetch beats in, events out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface bdlp_in_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic                          raw_pin;
  logic [bdlp_pkg::TimerW-1:0]   elapsed;

  modport source (output valid, kind, raw_pin, elapsed, input ready);
  modport sink   (input valid, kind, raw_pin, elapsed, output ready);
endinterface

interface bdlp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_code;

  modport source (output valid, event_code, input ready);
  modport sink   (input valid, event_code, output ready);
endinterface

// ----- rtl/bdlp_step.sv -----
// ----------------------------------------------------------------------------
// bdlp_step
// Next-state logic for one beat: debounce, press/release, long-press and fetch clear.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bdlp_step (
  input  bdlp_pkg::cfg_t                cfg_i,
  input  bdlp_pkg::state_t              state_i,
  input  logic                          kind_i,
  input  logic                          raw_pin_i,
  input  logic [bdlp_pkg::TimerW-1:0]   elapsed_i,
  output bdlp_pkg::state_t              state_o,
  output bdlp_pkg::event_e              event_o
);

  logic                        pin_pressed;
  logic                        below;
  logic                        settled;
  logic [bdlp_pkg::TimerW-1:0] steady_sum;
  logic [bdlp_pkg::TimerW-1:0] held_sum;

  assign pin_pressed = (raw_pin_i == cfg_i.press_level);
  assign below       = (state_i.steady_timer < cfg_i.debounce_time);
  assign steady_sum  = bdlp_pkg::sat_add(state_i.steady_timer, elapsed_i);
  assign held_sum    = bdlp_pkg::sat_add(state_i.held_timer, elapsed_i);
  assign settled     = !below || (steady_sum >= cfg_i.debounce_time);
  assign event_o     = state_i.pending;

  always_comb begin
    state_o = state_i;
    if (kind_i) begin
      state_o.pending = bdlp_pkg::EV_NONE;
    end else if (pin_pressed != state_i.prev_pin_pressed) begin
      state_o.prev_pin_pressed = pin_pressed;
      state_o.steady_timer     = '0;
    end else begin
      if (below) begin
        state_o.steady_timer = steady_sum;
      end
      if (settled) begin
        if (state_i.stable_pressed != pin_pressed) begin
          state_o.stable_pressed = pin_pressed;
          if (pin_pressed) begin
            state_o.held_timer = '0;
            state_o.long_done  = 1'b0;
            state_o.pending    = bdlp_pkg::EV_PRESS;
          end else begin
            state_o.pending = state_i.long_done ? bdlp_pkg::EV_RELEASE
                                                : bdlp_pkg::EV_SHORT;
          end
        end else if (state_i.stable_pressed) begin
          state_o.held_timer = held_sum;
          if (!state_i.long_done && held_sum >= cfg_i.long_press_time) begin
            state_o.long_done = 1'b1;
            state_o.pending   = bdlp_pkg::EV_LONG;
          end
        end
      end
    end
  end

endmodule

// ----- rtl/button_debounce_long_press_unit.sv -----
// ----------------------------------------------------------------------------
// button_debounce_long_press_unit
// Button qualifier: debounces a sampled pin and reports press, short,
// long and release events.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   carries beats of kind scan (raw pin level plus elapsed ms) or
//          fetch. A scan updates the debounce and hold timers and gives no
//          result. A fetch returns the latched event on out_o and clears it.
//   cfg_*  writes active level, debounce time and long-press time; the user
//          writes only while the unit is idle, unchecked by the unit; a write to an unused index is dropped.
// Timing:
//   One beat is accepted every cycle while in_i.ready is high. All work for
//   a beat is done in the cycle it is accepted, in one pass through the timer
//   adders and compares; the event of a fetch appears on out_o in the next cycle.
// Reset:
//   rst_ni clears all timers and flags, drops any latched event and any
//   waiting result, and loads the register defaults (active low, 20 ms,
//   1000 ms).
// Stalls:
//   The output register holds a result until taken; in_i.ready stays high
//   while that register is empty or being emptied in the same cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_debounce_long_press_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bdlp_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [bdlp_pkg::CfgDataW-1:0]   cfg_data_i,
  bdlp_in_if.sink                         in_i,
  bdlp_out_if.source                      out_o
);

  bdlp_pkg::cfg_t   cfg_q;
  bdlp_pkg::state_t state_q, state_d;
  bdlp_pkg::event_e step_event;
  bdlp_pkg::event_e event_q;
  logic             out_valid_q;
  logic             in_fire;
  logic             out_fire;

  assign in_i.ready       = !out_valid_q || out_o.ready;
  assign in_fire          = in_i.valid && in_i.ready;
  assign out_fire         = out_valid_q && out_o.ready;
  assign out_o.valid      = out_valid_q;
  assign out_o.event_code = event_q;

  bdlp_step u_step (
    .cfg_i     (cfg_q),
    .state_i   (state_q),
    .kind_i    (in_i.kind),
    .raw_pin_i (in_i.raw_pin),
    .elapsed_i (in_i.elapsed),
    .state_o   (state_d),
    .event_o   (step_event)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_level     <= bdlp_pkg::RstActiveLevel;
      cfg_q.debounce_time   <= bdlp_pkg::RstDebounce;
      cfg_q.long_press_time <= bdlp_pkg::RstLongPress;
    end else if (cfg_we_i) begin
      unique case (bdlp_pkg::cfg_idx_e'(cfg_idx_i))
        bdlp_pkg::CFG_ACTIVE_LEVEL: cfg_q.press_level     <= cfg_data_i[0];
        bdlp_pkg::CFG_DEBOUNCE:     cfg_q.debounce_time   <= cfg_data_i;
        bdlp_pkg::CFG_LONG_PRESS:   cfg_q.long_press_time <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bdlp_pkg::StateRst;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        state_q <= state_d;
      end
      if (in_fire && in_i.kind) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && in_i.kind) begin
      event_q <= step_event;
    end
  end

  a_fetch_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.kind |=> out_valid_q && event_q == $past(state_q.pending))
    else $error("fetch did not return the latched event");

  a_fetch_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.kind |=> state_q.pending == bdlp_pkg::EV_NONE)
    else $error("fetch did not clear the latched event");

  a_press_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q.stable_pressed) |-> state_q.pending == bdlp_pkg::EV_PRESS &&
      state_q.held_timer == '0 && !state_q.long_done)
    else $error("press did not latch a press event with cleared hold state");

endmodule
